// ===== hw/rtl/xcpm_pkg.sv =====
// xcpm_pkg: shared types, codes and helpers for the xc potential matrix element core
// no dependencies
`default_nettype none

package xcpm_pkg;

  localparam logic [3:0] OP_LOAD_WEIGHT = 4'd0;
  localparam logic [3:0] OP_LOAD_GRADZ  = 4'd7;
  localparam logic [3:0] OP_LOAD_BASIS  = 4'd8;
  localparam logic [3:0] OP_LOAD_BLAPL  = 4'd12;
  localparam logic [3:0] OP_COMPUTE     = 4'd13;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_LDA  = 2'd1;
  localparam logic [1:0] MODE_GGA  = 2'd2;
  localparam logic [1:0] MODE_META = 2'd3;

  localparam logic REG_MODE       = 1'b0;
  localparam logic REG_GRID_COUNT = 1'b1;

  localparam logic [8:0] GRID_COUNT_RESET = 9'd256;

  localparam int NUM_GRID_TABLES  = 8;
  localparam int NUM_BASIS_TABLES = 5;

  // grid table slots
  localparam int GT_WEIGHT = 0;
  localparam int GT_VRHO   = 1;
  localparam int GT_VSIGMA = 2;
  localparam int GT_VLAPL  = 3;
  localparam int GT_VTAU   = 4;
  localparam int GT_DX     = 5;
  localparam int GT_DY     = 6;
  localparam int GT_DZ     = 7;

  // basis table slots
  localparam int BT_VAL  = 0;
  localparam int BT_GX   = 1;
  localparam int BT_GY   = 2;
  localparam int BT_GZ   = 3;
  localparam int BT_LAPL = 4;

  localparam logic [4:0] STEP_FIRST   = 5'd0;
  localparam logic [4:0] STEP_LDA_END = 5'd1;
  localparam logic [4:0] STEP_GGA_END = 5'd11;
  localparam logic [4:0] STEP_ACC     = 5'd19;

  localparam logic signed [63:0] SAT_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic [3:0]         op;
    logic [4:0]         row_index;
    logic [4:0]         col_index;
    logic [7:0]         grid_index;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         out_row;
    logic [4:0]         out_col;
    logic signed [63:0] element;
    logic               saturated;
  } out_item_t;

  typedef enum logic [4:0] {
    OPND_AI, OPND_AJ, OPND_XI, OPND_XJ, OPND_YI, OPND_YJ, OPND_ZI, OPND_ZJ,
    OPND_LI, OPND_LJ, OPND_VRHO, OPND_VS2, OPND_C, OPND_VL, OPND_W,
    OPND_DX, OPND_DY, OPND_DZ, OPND_TMP, OPND_GX, OPND_GY, OPND_GZ,
    OPND_S, OPND_Q, OPND_INNER
  } opnd_t;

  typedef enum logic [2:0] {
    DST_TMP, DST_GX, DST_GY, DST_GZ, DST_S, DST_Q, DST_INNER, DST_ACC
  } dst_t;

  typedef struct packed {
    opnd_t a;
    opnd_t b;
    dst_t  dst;
    logic  acc;
  } uop_t;

  typedef struct packed {
    logic       clear;
    logic       rd;
    logic       go;
    logic [4:0] step;
  } ctl_cmd_t;

  typedef struct packed {
    logic mul_done;
  } dp_stat_t;

  function automatic uop_t step_decode(input logic [4:0] s);
    uop_t u;
    case (s)
      5'd0:  u = '{OPND_AI,   OPND_AJ,    DST_TMP,   1'b0};
      5'd1:  u = '{OPND_VRHO, OPND_TMP,   DST_INNER, 1'b0};
      5'd2:  u = '{OPND_XI,   OPND_AJ,    DST_GX,    1'b0};
      5'd3:  u = '{OPND_AI,   OPND_XJ,    DST_GX,    1'b1};
      5'd4:  u = '{OPND_YI,   OPND_AJ,    DST_GY,    1'b0};
      5'd5:  u = '{OPND_AI,   OPND_YJ,    DST_GY,    1'b1};
      5'd6:  u = '{OPND_ZI,   OPND_AJ,    DST_GZ,    1'b0};
      5'd7:  u = '{OPND_AI,   OPND_ZJ,    DST_GZ,    1'b1};
      5'd8:  u = '{OPND_DX,   OPND_GX,    DST_S,     1'b0};
      5'd9:  u = '{OPND_DY,   OPND_GY,    DST_S,     1'b1};
      5'd10: u = '{OPND_DZ,   OPND_GZ,    DST_S,     1'b1};
      5'd11: u = '{OPND_VS2,  OPND_S,     DST_INNER, 1'b1};
      5'd12: u = '{OPND_XI,   OPND_XJ,    DST_Q,     1'b0};
      5'd13: u = '{OPND_YI,   OPND_YJ,    DST_Q,     1'b1};
      5'd14: u = '{OPND_ZI,   OPND_ZJ,    DST_Q,     1'b1};
      5'd15: u = '{OPND_C,    OPND_Q,     DST_INNER, 1'b1};
      5'd16: u = '{OPND_AI,   OPND_LJ,    DST_TMP,   1'b0};
      5'd17: u = '{OPND_LI,   OPND_AJ,    DST_TMP,   1'b1};
      5'd18: u = '{OPND_VL,   OPND_TMP,   DST_INNER, 1'b1};
      default: u = '{OPND_W,  OPND_INNER, DST_ACC,   1'b1};
    endcase
    return u;
  endfunction

  // saturating add, bit 64 flags clipping
  function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return {1'b1, (b[63] ? SAT_MIN : SAT_MAX)};
    end
    return {1'b0, s};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/xcpm_ram.sv =====
// xcpm_ram: generic single write, single registered read memory
// no dependencies
`default_nettype none

module xcpm_ram #(
  parameter int W = 32,
  parameter int D = 256
) (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  wire logic [W-1:0]                      wdata,
  input  wire logic                              re,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic      [W-1:0]                      rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/xcpm_smul.sv =====
// xcpm_smul: iterative signed q16.48 multiplier, four 32x32 partial products
// depends on xcpm_pkg
`default_nettype none

module xcpm_smul (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               go,
  input  wire logic signed [63:0] a,
  input  wire logic signed [63:0] b,
  output logic                    done,
  output logic signed [63:0]      result,
  output logic                    sat
);

  import xcpm_pkg::*;

  localparam logic [2:0] CNT_IDLE  = 3'd0;
  localparam logic [2:0] CNT_FIRST = 3'd1;
  localparam logic [2:0] CNT_LAST  = 3'd4;
  localparam logic [2:0] CNT_FIN   = 3'd5;

  logic [2:0]   cnt_r, cnt_nxt;
  logic [63:0]  ua_r, ub_r;
  logic         neg_r;
  logic [127:0] prod_r;
  logic [1:0]   sel;
  logic [31:0]  half_a, half_b;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [63:0]  r;
  logic         busy_pp;

  assign busy_pp = (cnt_r >= CNT_FIRST) && (cnt_r <= CNT_LAST);

  always_comb begin
    sel    = 2'(cnt_r - CNT_FIRST);
    half_a = sel[0] ? ua_r[63:32] : ua_r[31:0];
    half_b = sel[1] ? ub_r[63:32] : ub_r[31:0];
    pp     = 64'(half_a) * 64'(half_b);
    pp_sh  = {64'b0, pp} << {sel[0] & sel[1], sel[0] ^ sel[1], 5'b0};
  end

  always_comb begin
    if (go) begin
      cnt_nxt = CNT_FIRST;
    end else if (busy_pp) begin
      cnt_nxt = cnt_r + 3'd1;
    end else begin
      cnt_nxt = CNT_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_IDLE;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      ua_r   <= a[63] ? 64'(-a) : 64'(a);
      ub_r   <= b[63] ? 64'(-b) : 64'(b);
      neg_r  <= a[63] ^ b[63];
      prod_r <= '0;
    end else if (busy_pp) begin
      prod_r <= prod_r + pp_sh;
    end
  end

  always_comb begin
    r      = prod_r[111:48];
    sat    = 1'b0;
    result = r;
    if (|prod_r[127:112]) begin
      sat    = 1'b1;
      result = neg_r ? SAT_MIN : SAT_MAX;
    end else if (!neg_r) begin
      if (r[63]) begin
        sat    = 1'b1;
        result = SAT_MAX;
      end
    end else if (r[63] && |r[62:0]) begin
      sat    = 1'b1;
      result = SAT_MIN;
    end else begin
      result = -r;
    end
  end

  assign done = (cnt_r == CNT_FIN);

endmodule

`default_nettype wire

// ===== hw/rtl/xcpm_datapath.sv =====
// xcpm_datapath: grid and basis tables, operand select, multiplier and accumulator
// depends on xcpm_pkg, xcpm_ram, xcpm_smul
`default_nettype none

module xcpm_datapath #(
  parameter int NBASIS = 32,
  parameter int NGRIDS = 256,
  parameter int GW     = 8,
  parameter int AW     = 13
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire xcpm_pkg::in_item_t  in_data,
  input  wire logic                in_acc,
  input  wire xcpm_pkg::ctl_cmd_t  cmd,
  input  wire logic [GW-1:0]       k,
  output xcpm_pkg::dp_stat_t       stat,
  output xcpm_pkg::out_item_t      out_data
);

  import xcpm_pkg::*;

  logic [31:0] g_ext, wb_addr32, ri_addr32, rj_addr32;
  logic        g_ok, row_ok;
  logic [GW-1:0] g_waddr;
  logic [AW-1:0] b_waddr, b_raddr_i, b_raddr_j;

  logic [31:0] grid_rd  [NUM_GRID_TABLES];
  logic [31:0] bas_rd_i [NUM_BASIS_TABLES];
  logic [31:0] bas_rd_j [NUM_BASIS_TABLES];

  logic [4:0] row_r, col_r;
  logic signed [63:0] tmp_r, gx_r, gy_r, gz_r, s_r, q_r, inner_r, acc_r;
  logic clip_r;

  uop_t uop;
  logic signed [63:0] opa, opb, mres, cur;
  logic msat, mdone;
  logic [64:0] newv;

  assign g_ext     = 32'(in_data.grid_index);
  assign g_ok      = g_ext < 32'(NGRIDS);
  assign row_ok    = 32'(in_data.row_index) < 32'(NBASIS);
  assign g_waddr   = g_ext[GW-1:0];
  assign wb_addr32 = 32'(in_data.row_index) * 32'(NGRIDS) + g_ext;
  assign ri_addr32 = 32'(row_r) * 32'(NGRIDS) + 32'(k);
  assign rj_addr32 = 32'(col_r) * 32'(NGRIDS) + 32'(k);
  assign b_waddr   = wb_addr32[AW-1:0];
  assign b_raddr_i = ri_addr32[AW-1:0];
  assign b_raddr_j = rj_addr32[AW-1:0];

  for (genvar t = 0; t < NUM_GRID_TABLES; t++) begin : g_grid
    logic we;
    assign we = in_acc && g_ok && (in_data.op == OP_LOAD_WEIGHT + 4'(t));
    xcpm_ram #(.W(32), .D(NGRIDS)) u_ram (
      .clk(clk), .we(we), .waddr(g_waddr), .wdata(in_data.value),
      .re(cmd.rd), .raddr(k), .rdata(grid_rd[t])
    );
  end

  for (genvar t = 0; t < NUM_BASIS_TABLES; t++) begin : g_basis
    logic we;
    assign we = in_acc && g_ok && row_ok && (in_data.op == OP_LOAD_BASIS + 4'(t));
    xcpm_ram #(.W(32), .D(NBASIS * NGRIDS)) u_ram_i (
      .clk(clk), .we(we), .waddr(b_waddr), .wdata(in_data.value),
      .re(cmd.rd), .raddr(b_raddr_i), .rdata(bas_rd_i[t])
    );
    xcpm_ram #(.W(32), .D(NBASIS * NGRIDS)) u_ram_j (
      .clk(clk), .we(we), .waddr(b_waddr), .wdata(in_data.value),
      .re(cmd.rd), .raddr(b_raddr_j), .rdata(bas_rd_j[t])
    );
  end

  function automatic logic signed [63:0] wide(input logic [31:0] v);
    return {{8{v[31]}}, v, 24'b0};
  endfunction

  function automatic logic signed [63:0] pick(
    input opnd_t sel,
    input logic signed [63:0] tmp, gx, gy, gz, s, q, inner
  );
    logic signed [63:0] r;
    case (sel)
      OPND_AI:    r = wide(bas_rd_i[BT_VAL]);
      OPND_AJ:    r = wide(bas_rd_j[BT_VAL]);
      OPND_XI:    r = wide(bas_rd_i[BT_GX]);
      OPND_XJ:    r = wide(bas_rd_j[BT_GX]);
      OPND_YI:    r = wide(bas_rd_i[BT_GY]);
      OPND_YJ:    r = wide(bas_rd_j[BT_GY]);
      OPND_ZI:    r = wide(bas_rd_i[BT_GZ]);
      OPND_ZJ:    r = wide(bas_rd_j[BT_GZ]);
      OPND_LI:    r = wide(bas_rd_i[BT_LAPL]);
      OPND_LJ:    r = wide(bas_rd_j[BT_LAPL]);
      OPND_VRHO:  r = wide(grid_rd[GT_VRHO]);
      OPND_VS2:   r = {{7{grid_rd[GT_VSIGMA][31]}}, grid_rd[GT_VSIGMA], 25'b0};
      OPND_C:     r = {{9{grid_rd[GT_VTAU][31]}}, grid_rd[GT_VTAU], 23'b0}
                    + {{7{grid_rd[GT_VLAPL][31]}}, grid_rd[GT_VLAPL], 25'b0};
      OPND_VL:    r = wide(grid_rd[GT_VLAPL]);
      OPND_W:     r = wide(grid_rd[GT_WEIGHT]);
      OPND_DX:    r = wide(grid_rd[GT_DX]);
      OPND_DY:    r = wide(grid_rd[GT_DY]);
      OPND_DZ:    r = wide(grid_rd[GT_DZ]);
      OPND_TMP:   r = tmp;
      OPND_GX:    r = gx;
      OPND_GY:    r = gy;
      OPND_GZ:    r = gz;
      OPND_S:     r = s;
      OPND_Q:     r = q;
      OPND_INNER: r = inner;
      default:    r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    uop = step_decode(cmd.step);
    opa = pick(uop.a, tmp_r, gx_r, gy_r, gz_r, s_r, q_r, inner_r);
    opb = pick(uop.b, tmp_r, gx_r, gy_r, gz_r, s_r, q_r, inner_r);
  end

  xcpm_smul u_smul (
    .clk(clk), .rst_n(rst_n), .go(cmd.go), .a(opa), .b(opb),
    .done(mdone), .result(mres), .sat(msat)
  );

  always_comb begin
    case (uop.dst)
      DST_TMP:   cur = tmp_r;
      DST_GX:    cur = gx_r;
      DST_GY:    cur = gy_r;
      DST_GZ:    cur = gz_r;
      DST_S:     cur = s_r;
      DST_Q:     cur = q_r;
      DST_INNER: cur = inner_r;
      default:   cur = acc_r;
    endcase
    newv = uop.acc ? sat_add(cur, mres) : {1'b0, mres};
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      row_r  <= in_data.row_index;
      col_r  <= in_data.col_index;
      acc_r  <= '0;
      clip_r <= 1'b0;
    end else if (mdone) begin
      clip_r <= clip_r | msat | newv[64];
      case (uop.dst)
        DST_TMP:   tmp_r   <= newv[63:0];
        DST_GX:    gx_r    <= newv[63:0];
        DST_GY:    gy_r    <= newv[63:0];
        DST_GZ:    gz_r    <= newv[63:0];
        DST_S:     s_r     <= newv[63:0];
        DST_Q:     q_r     <= newv[63:0];
        DST_INNER: inner_r <= newv[63:0];
        default:   acc_r   <= newv[63:0];
      endcase
    end
  end

  assign stat.mul_done      = mdone;
  assign out_data.out_row   = row_r;
  assign out_data.out_col   = col_r;
  assign out_data.element   = acc_r;
  assign out_data.saturated = clip_r;

endmodule

`default_nettype wire

// ===== hw/rtl/xcpm_ctrl.sv =====
// xcpm_ctrl: configuration registers and sequencer over grid points and steps
// depends on xcpm_pkg
`default_nettype none

module xcpm_ctrl #(
  parameter int NBASIS = 32,
  parameter int NGRIDS = 256,
  parameter int GW     = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [3:0]         op,
  input  wire logic [4:0]         row_index,
  input  wire logic [4:0]         col_index,
  output logic                    busy,
  output logic                    out_strobe,
  input  wire logic               cfg_wr,
  input  wire logic               cfg_index,
  input  wire logic [8:0]         cfg_data,
  input  wire xcpm_pkg::dp_stat_t stat,
  output xcpm_pkg::ctl_cmd_t      cmd,
  output logic [GW-1:0]           k
);

  import xcpm_pkg::*;

  localparam int KW = ($clog2(NGRIDS + 1) > 9) ? $clog2(NGRIDS + 1) : 9;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_RUN  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0]    mode_r;
  logic [8:0]    gcnt_r;
  logic [KW-1:0] k_r, k_nxt, n;
  logic [4:0]    step_r, step_nxt, step_inc;
  logic          accept, go_compute, last_step;

  assign n = (KW'(gcnt_r) > KW'(NGRIDS)) ? KW'(NGRIDS) : KW'(gcnt_r);
  assign accept = start && (state_r == ST_IDLE) && (op == OP_COMPUTE);
  assign go_compute = (mode_r != MODE_NONE) && (32'(row_index) < 32'(NBASIS))
                    && (32'(col_index) < 32'(NBASIS)) && (n != '0);
  assign last_step = (step_r == STEP_ACC);

  always_comb begin
    if (step_r == STEP_LDA_END && mode_r == MODE_LDA) begin
      step_inc = STEP_ACC;
    end else if (step_r == STEP_GGA_END && mode_r == MODE_GGA) begin
      step_inc = STEP_ACC;
    end else begin
      step_inc = step_r + 5'd1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          k_nxt     = '0;
          step_nxt  = STEP_FIRST;
          state_nxt = go_compute ? ST_READ : ST_OUT;
        end
      end
      ST_READ: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_RUN;
      ST_RUN: begin
        if (stat.mul_done) begin
          if (!last_step) begin
            step_nxt  = step_inc;
            state_nxt = ST_MUL;
          end else begin
            step_nxt = STEP_FIRST;
            k_nxt    = k_r + KW'(1);
            state_nxt = (k_r + KW'(1) == n) ? ST_OUT : ST_READ;
          end
        end
      end
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      step_r  <= STEP_FIRST;
      mode_r  <= MODE_NONE;
      gcnt_r  <= GRID_COUNT_RESET;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      step_r  <= step_nxt;
      if (cfg_wr && cfg_index == REG_MODE) begin
        mode_r <= cfg_data[1:0];
      end
      if (cfg_wr && cfg_index == REG_GRID_COUNT) begin
        gcnt_r <= cfg_data;
      end
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = (state_r == ST_OUT);
  assign cmd.clear  = accept;
  assign cmd.rd     = (state_r == ST_READ);
  assign cmd.go     = (state_r == ST_MUL);
  assign cmd.step   = step_r;
  assign k          = k_r[GW-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/xc_potential_matrix_element_core.sv =====
// xc_potential_matrix_element_core: top level of the xc matrix element engine
// depends on xcpm_pkg, xcpm_ctrl, xcpm_datapath
//
// usage:
//   in channel: an item is taken when start is high and busy is low.
//   load items (op 0..12) write one table entry at that edge; busy stays low,
//   so loads can be issued every cycle.
//   a compute item (op 13) raises busy; the result appears on out_data for
//   exactly one cycle with out_strobe high, then busy falls.
//   per grid point: a table read, then each multiply step in turn on the
//   shared iterative multiplier (3 steps lda, 13 gga, 20 meta-gga).
//   compute: grid points 0 .. n-1 are processed, n the grid count clipped to NGRIDS;
//   busy is high from the accepting edge until the strobe cycle ends; with mode none,
//   grid count zero or an index out of range no grid point is processed before the strobe.
//   the multiplier (four 32x32 partial products per step) sets the rate.
//   cfg channel: cfg_ready is always high; write only while busy is low.
//   reset: mode none, grid count 256; tables are undefined until loaded.
//   the receiver cannot stall: each result is shown for one cycle only.
`default_nettype none

module xc_potential_matrix_element_core #(
  parameter int NBASIS = 32,
  parameter int NGRIDS = 256
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire xcpm_pkg::in_item_t  in_data,
  output logic                     out_strobe,
  output xcpm_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [8:0]          cfg_data
);

  import xcpm_pkg::*;

  localparam int GW = (NGRIDS > 1) ? $clog2(NGRIDS) : 1;
  localparam int AW = (NBASIS * NGRIDS > 1) ? $clog2(NBASIS * NGRIDS) : 1;

  ctl_cmd_t      cmd;
  dp_stat_t      stat;
  logic [GW-1:0] k;
  logic          in_acc;

  assign cfg_ready = 1'b1;
  assign in_acc    = start && !busy;

  xcpm_ctrl #(.NBASIS(NBASIS), .NGRIDS(NGRIDS), .GW(GW)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .op(in_data.op),
    .row_index(in_data.row_index), .col_index(in_data.col_index),
    .busy(busy), .out_strobe(out_strobe),
    .cfg_wr(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .stat(stat), .cmd(cmd), .k(k)
  );

  xcpm_datapath #(.NBASIS(NBASIS), .NGRIDS(NGRIDS), .GW(GW), .AW(AW)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .in_acc(in_acc),
    .cmd(cmd), .k(k), .stat(stat), .out_data(out_data)
  );

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result strobe outside compute");

  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.op == OP_COMPUTE) |=> busy)
    else $error("compute item did not start");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.op != OP_COMPUTE) |=> !busy)
    else $error("non compute item made the block busy");

  a_strobe_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !busy && !out_strobe)
    else $error("block stayed busy after result");

endmodule

`default_nettype wire
